FILE: rtl/nlc_pkg.sv
`timescale 1ns / 1ps

package nlc_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_INT    = 3'd3,
        PH_HEX    = 3'd4,
        PH_FRAC   = 3'd5,
        PH_BAD    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_INT   = 2'd1,
        KIND_HEX   = 2'd2,
        KIND_FLOAT = 2'd3
    } kind_t;

    typedef struct packed {
        logic is_nul;
        logic is_spacing;
        logic is_sign;
        logic is_zero;
        logic is_dec;
        logic is_hex;
        logic is_dot;
        logic is_x;
    } char_class_t;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;

endpackage

FILE: rtl/nlc_char_class.sv
`timescale 1ns / 1ps

module nlc_char_class (
    input  logic [7:0]                char_byte,
    output nlc_pkg::char_class_t      char_class
);
    import nlc_pkg::*;

    logic dec_digit;

    assign dec_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);

    always_comb
    begin
        char_class.is_nul     = (char_byte == CHAR_NUL);
        char_class.is_spacing = (char_byte == CHAR_SPACE) || (char_byte == CHAR_TAB);
        char_class.is_sign    = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS);
        char_class.is_zero    = (char_byte == CHAR_ZERO);
        char_class.is_dec     = dec_digit;
        char_class.is_hex     = dec_digit ||
                                ((char_byte >= CHAR_LC_A) && (char_byte <= CHAR_LC_F)) ||
                                ((char_byte >= CHAR_UC_A) && (char_byte <= CHAR_UC_F));
        char_class.is_dot     = (char_byte == CHAR_DOT);
        char_class.is_x       = (char_byte == CHAR_LC_X) || (char_byte == CHAR_UC_X);
    end

endmodule

FILE: rtl/nlc_phase_fsm.sv
`timescale 1ns / 1ps

module nlc_phase_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  nlc_pkg::char_class_t char_class,
    output nlc_pkg::kind_t       end_kind
);
    import nlc_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t body_phase;

    // first character of the number body
    always_comb
    begin
        if (char_class.is_zero)
            body_phase = PH_ZERO;
        else if (char_class.is_dec)
            body_phase = PH_INT;
        else if (char_class.is_dot)
            body_phase = PH_FRAC;
        else
            body_phase = PH_BAD;
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (advance)
        begin
            if (char_class.is_nul)
                phase_next = PH_LEAD;
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (char_class.is_spacing)
                            phase_next = PH_LEAD;
                        else if (char_class.is_sign)
                            phase_next = PH_SIGNED;
                        else
                            phase_next = body_phase;
                    end
                    PH_SIGNED:
                        phase_next = body_phase;
                    PH_ZERO:
                    begin
                        if (char_class.is_x)
                            phase_next = PH_HEX;
                        else if (char_class.is_dec)
                            phase_next = PH_INT;
                        else if (char_class.is_dot)
                            phase_next = PH_FRAC;
                        else
                            phase_next = PH_BAD;
                    end
                    PH_INT:
                    begin
                        if (char_class.is_dec)
                            phase_next = PH_INT;
                        else if (char_class.is_dot)
                            phase_next = PH_FRAC;
                        else
                            phase_next = PH_BAD;
                    end
                    PH_HEX:
                        phase_next = char_class.is_hex ? PH_HEX : PH_BAD;
                    PH_FRAC:
                        phase_next = char_class.is_dec ? PH_FRAC : PH_BAD;
                    default:
                        phase_next = PH_BAD;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_ZERO,
            PH_INT:  end_kind = KIND_INT;
            PH_HEX:  end_kind = KIND_HEX;
            PH_FRAC: end_kind = KIND_FLOAT;
            default: end_kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_LEAD;
        else
            phase_reg <= phase_next;
    end

endmodule

FILE: rtl/numeric_literal_classifier_top.sv
`timescale 1ns / 1ps
// Flow: a transferred byte is held in byte_reg and classified from there; the result for a NUL
// byte is loaded into the output register (out_valid/kind) when that byte advances.
// Throughput: one byte per cycle, unless a NUL byte is held up by a stalled output.
// A NUL byte stalls input only while its result cannot enter the held output register.
// Reset: asynchronous; clears both valid flags and returns the phase to leading blanks.
module numeric_literal_classifier_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind
);
    import nlc_pkg::*;

    logic        byte_valid_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    logic [1:0]  kind_reg;

    char_class_t char_class;
    kind_t       end_kind;
    logic        out_free;
    logic        s1_advance;
    logic        in_xfer;
    logic        result_load;

    nlc_char_class u_class (
        .char_byte  (byte_reg),
        .char_class (char_class)
    );

    nlc_phase_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_advance),
        .char_class (char_class),
        .end_kind   (end_kind)
    );

    assign out_free    = !out_valid_reg || !out_stall;
    assign s1_advance  = byte_valid_reg && (!char_class.is_nul || out_free);
    assign result_load = s1_advance && char_class.is_nul;
    assign in_stall    = byte_valid_reg && !s1_advance;
    assign in_xfer     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_xfer)
            byte_valid_reg <= 1'b1;
        else if (s1_advance)
            byte_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            byte_reg <= char_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (result_load)
            kind_reg <= 2'(end_kind);
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;

    a_stall_only_on_blocked_nul: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (byte_valid_reg && char_class.is_nul && out_valid_reg && out_stall)
    ) else $error("input stalled without a blocked NUL");

    a_result_from_nul: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(byte_valid_reg && char_class.is_nul)
    ) else $error("result produced without a NUL byte");

    a_result_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !result_load) |=> !out_valid_reg
    ) else $error("taken result not cleared");

endmodule

FILE: test/tb_numeric_literal_classifier_top.sv
`timescale 1ns / 1ps

module tb_numeric_literal_classifier_top;
    import nlc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 600;

    typedef struct {
        logic [7:0] value;
        bit         hold;
    } char_xfer_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_byte;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;

    char_xfer_t bytes_pending[$];
    kind_t      kinds_due[$];
    phase_t     cur_phase;
    bit         in_taken;
    bit         hold_next;
    int         bytes_taken;
    int         total_bytes;
    int         mismatches;
    int         cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    numeric_literal_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic phase_t advance_phase(phase_t p, logic [7:0] c);
        phase_t nxt;
        logic   dec;
        logic   hex;
        logic   blank;
        logic   sign;
        dec   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        hex   = dec || ((c >= CHAR_LC_A) && (c <= CHAR_LC_F))
                    || ((c >= CHAR_UC_A) && (c <= CHAR_UC_F));
        blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
        sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
        nxt   = PH_BAD;
        case (p)
            PH_LEAD, PH_SIGNED:
            begin
                if (p == PH_LEAD && blank)
                    nxt = PH_LEAD;
                else if (p == PH_LEAD && sign)
                    nxt = PH_SIGNED;
                else if (c == CHAR_ZERO)
                    nxt = PH_ZERO;
                else if (dec)
                    nxt = PH_INT;
                else if (c == CHAR_DOT)
                    nxt = PH_FRAC;
            end
            PH_ZERO:
            begin
                if (c == CHAR_LC_X || c == CHAR_UC_X)
                    nxt = PH_HEX;
                else if (dec)
                    nxt = PH_INT;
                else if (c == CHAR_DOT)
                    nxt = PH_FRAC;
            end
            PH_INT:
            begin
                if (dec)
                    nxt = PH_INT;
                else if (c == CHAR_DOT)
                    nxt = PH_FRAC;
            end
            PH_HEX:
            begin
                if (hex)
                    nxt = PH_HEX;
            end
            PH_FRAC:
            begin
                if (dec)
                    nxt = PH_FRAC;
            end
            default:
            begin
                nxt = PH_BAD;
            end
        endcase
        return nxt;
    endfunction

    task automatic push_byte(logic [7:0] v);
        char_xfer_t x;
        x.value   = v;
        x.hold    = hold_next;
        hold_next = 1'b0;
        bytes_pending.push_back(x);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
        push_byte(CHAR_NUL);
    endtask

    function automatic logic [7:0] pick_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] pick_dec_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed literals with random content, plus noise and broken ones.
    task automatic push_random_literal();
        int form;
        form = $urandom_range(0, 5);
        repeat ($urandom_range(0, 2))
            push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        if ($urandom_range(0, 2) == 0)
            push_byte($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        case (form)
            0, 1:
            begin
                repeat ($urandom_range(1, 6))
                    push_byte(pick_dec_char());
            end
            2:
            begin
                push_byte(CHAR_ZERO);
                push_byte($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
                repeat ($urandom_range(0, 5))
                    push_byte(pick_hex_char());
            end
            3, 4:
            begin
                repeat ($urandom_range(0, 3))
                    push_byte(pick_dec_char());
                push_byte(CHAR_DOT);
                repeat ($urandom_range(0, 3))
                    push_byte(pick_dec_char());
            end
            default:
            begin
                repeat ($urandom_range(0, 6))
                    push_byte(8'($urandom_range(1, 255)));
            end
        endcase
        // Corrupt a share of the literals with a stray byte.
        if ($urandom_range(0, 5) == 0)
        begin
            push_byte(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 1))
                push_byte(pick_dec_char());
        end
        push_byte(CHAR_NUL);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_byte = 8'h00;
        out_stall = 1'b0;
        hold_next = 1'b0;

        push_text("");
        push_text(" \t-");
        push_text("0x");
        push_text("0Xf");
        push_text(".");
        push_text("+ 9");
        push_text("0x.");
        push_text("19");
        push_text(".5");
        push_byte(8'h80);
        push_byte(CHAR_NUL);
        push_byte(8'hFF);
        push_byte(CHAR_NUL);

        // Let the directed strings drain before the random part starts.
        hold_next = 1'b1;
        while (bytes_pending.size() < 30 + RANDOM_BYTES)
            push_random_literal();
        total_bytes = bytes_pending.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_pending.size() != 0 || in_valid || kinds_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(*)
    begin
        if (bytes_taken < total_bytes / 3)
        begin
            send_idle_pct = 32;
            recv_idle_pct = 46;
        end
        else if (bytes_taken < 2 * total_bytes / 3)
        begin
            send_idle_pct = 46;
            recv_idle_pct = 32;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Driver: advance only when nothing is presented or the last transfer went through.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (!in_valid || in_taken)
            begin
                if (bytes_pending.size() != 0
                    && !(bytes_pending[0].hold && kinds_due.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    char_byte <= bytes_pending[0].value;
                    void'(bytes_pending.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and predictor.
    always @(posedge clk)
    begin
        kind_t due;
        if (!rst_n)
        begin
            cur_phase   = PH_LEAD;
            in_taken    <= 1'b0;
            bytes_taken <= 0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (kinds_due.size() == 0)
                begin
                    $error("kind: no result expected, actual %0d", kind);
                    mismatches++;
                end
                else
                begin
                    due = kinds_due.pop_front();
                    if (kind !== due)
                    begin
                        $error("kind: expected %0d, actual %0d", due, kind);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                bytes_taken <= bytes_taken + 1;
                if (char_byte == CHAR_NUL)
                begin
                    case (cur_phase)
                        PH_ZERO, PH_INT: kinds_due.push_back(KIND_INT);
                        PH_HEX:          kinds_due.push_back(KIND_HEX);
                        PH_FRAC:         kinds_due.push_back(KIND_FLOAT);
                        default:         kinds_due.push_back(KIND_NONE);
                    endcase
                    cur_phase = PH_LEAD;
                end
                else
                begin
                    cur_phase = advance_phase(cur_phase, char_byte);
                end
            end
        end
    end

endmodule

FILE: sim.f
rtl/nlc_pkg.sv
rtl/nlc_char_class.sv
rtl/nlc_phase_fsm.sv
rtl/numeric_literal_classifier_top.sv
test/tb_numeric_literal_classifier_top.sv
